FILE: rtl/core/e2c_pkg.sv
// ----------------------------------------------------------------------------
// e2c_pkg
// Types, constants and calendar helpers for the epoch-seconds to calendar
// converter.
// ----------------------------------------------------------------------------
package e2c_pkg;

  localparam int unsigned SecsW  = 32;
  localparam int unsigned YearW  = 12;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned HourW  = 5;
  localparam int unsigned MinW   = 6;
  localparam int unsigned SecW   = 6;

  localparam int unsigned NumMonths = 12;

  localparam logic [YearW-1:0] EpochYear = 12'd1970;

  // 86400 = 675 << 7, divide by 675 through a reciprocal
  localparam logic [9:0]  DayDivLo  = 10'd675;
  localparam logic [25:0] DayRecip  = 26'd50903316;
  // days / 365 estimate, off by at most one year either way
  localparam logic [15:0] YearRecip = 16'd45964;
  // 3600 = 225 << 4
  localparam logic [7:0]  HourDivLo = 8'd225;
  localparam logic [8:0]  HourRecip = 9'd291;
  // 60 = 15 << 2
  localparam logic [3:0]  MinDivLo  = 4'd15;
  localparam logic [10:0] MinRecip  = 11'd1092;

  // year 2100 is the only skipped century in range
  localparam logic [7:0] CenturyIdx = 8'd130;

  typedef logic [15:0] day_cnt_t;
  typedef logic [8:0]  doy_t;
  typedef logic [7:0]  yidx_t;
  typedef logic [3:0]  mon_idx_t;

  // days from the epoch to january 1 of year EpochYear + i
  function automatic day_cnt_t year_start(input yidx_t i);
    logic [8:0] ip1;
    day_cnt_t   r;
    ip1 = {1'b0, i} + 9'd1;
    r   = 16'(i) * 16'd365 + 16'(ip1[8:2]) - ((i > CenturyIdx) ? 16'd1 : 16'd0);
    return r;
  endfunction

  function automatic logic is_leap(input yidx_t i);
    return (i[1:0] == 2'd2) && (i != CenturyIdx);
  endfunction

  // cumulative day count at the end of month m, zero based
  function automatic doy_t month_end(input mon_idx_t m, input logic leap);
    doy_t r;
    case (m)
      4'd0:    r = 9'd31;
      4'd1:    r = leap ? 9'd60  : 9'd59;
      4'd2:    r = leap ? 9'd91  : 9'd90;
      4'd3:    r = leap ? 9'd121 : 9'd120;
      4'd4:    r = leap ? 9'd152 : 9'd151;
      4'd5:    r = leap ? 9'd182 : 9'd181;
      4'd6:    r = leap ? 9'd213 : 9'd212;
      4'd7:    r = leap ? 9'd244 : 9'd243;
      4'd8:    r = leap ? 9'd274 : 9'd273;
      4'd9:    r = leap ? 9'd305 : 9'd304;
      4'd10:   r = leap ? 9'd335 : 9'd334;
      4'd11:   r = leap ? 9'd366 : 9'd365;
      default: r = 9'd366;
    endcase
    return r;
  endfunction

  // day of year at which month m begins
  function automatic doy_t month_start(input mon_idx_t m, input logic leap);
    doy_t r;
    if (m == 4'd0) begin
      r = 9'd0;
    end else begin
      r = month_end(m - 4'd1, leap);
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/e2c_in_if.sv
// ----------------------------------------------------------------------------
// e2c_in_if
// Input channel: one epoch second count per transfer.
// ----------------------------------------------------------------------------
interface e2c_in_if;
  import e2c_pkg::*;

  logic             valid;
  logic             ready;
  logic [SecsW-1:0] unix_seconds;

  modport source (output valid, output unix_seconds, input ready);
  modport sink   (input valid, input unix_seconds, output ready);
endinterface

FILE: rtl/core/e2c_out_if.sv
// ----------------------------------------------------------------------------
// e2c_out_if
// Result channel: one calendar date and time of day per transfer.
// ----------------------------------------------------------------------------
interface e2c_out_if;
  import e2c_pkg::*;

  logic              valid;
  logic              ready;
  logic [YearW-1:0]  year;
  logic [MonthW-1:0] month;
  logic [DayW-1:0]   day;
  logic [HourW-1:0]  hour;
  logic [MinW-1:0]   minute;
  logic [SecW-1:0]   second;

  modport source (output valid, output year, output month, output day, output hour,
                  output minute, output second, input ready);
  modport sink   (input valid, input year, input month, input day, input hour,
                  input minute, input second, output ready);
endinterface

FILE: rtl/core/epoch_seconds_to_calendar_top.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_top
// Unix seconds to gregorian year, month, day, hour, minute and second.
// ----------------------------------------------------------------------------
// Eight-stage pipeline: a count of seconds can enter on every clock, one
// transfer per clock sustained while the output is not stalled. The whole pipe
// advances only when the output register is empty or being taken, so a stall
// on the result side holds every stage and the input ready falls with it.
// Divisions by 86400, 3600 and 60 use constant reciprocals with a single
// correction step; a /365 reciprocal estimate plus a closed-form year-start
// table gives the year, a parallel compare against the month ends the month.
module epoch_seconds_to_calendar_top (
  input  logic        clk,
  input  logic        rst_n,
  e2c_in_if.sink      in_ch,
  e2c_out_if.source   out_ch
);
  import e2c_pkg::*;

  logic       pipe_en;
  logic [7:0] vld_r, vld_nxt;

  // stage 1
  logic [24:0] s1_x_r, s1_x_nxt;
  logic [6:0]  s1_lo_r, s1_lo_nxt;
  logic [50:0] s1_prod_r, s1_prod_nxt;
  // stage 2
  logic [15:0] s2_q0_r, s2_q0_nxt;
  logic [25:0] s2_t_r, s2_t_nxt;
  logic [24:0] s2_x_r, s2_x_nxt;
  logic [6:0]  s2_lo_r, s2_lo_nxt;
  // stage 3
  logic [24:0] s3_diff;
  logic        s3_ge;
  logic [24:0] s3_rr;
  day_cnt_t    s3_days_r, s3_days_nxt;
  logic [16:0] s3_sod_r, s3_sod_nxt;
  // stage 4
  logic [31:0] s4_yprod_r, s4_yprod_nxt;
  day_cnt_t    s4_days_r, s4_days_nxt;
  logic [21:0] s4_hprod_r, s4_hprod_nxt;
  logic [16:0] s4_sod_r, s4_sod_nxt;
  // stage 5
  yidx_t       s5_e_r, s5_e_nxt;
  day_cnt_t    s5_ym1_r, s5_ym1_nxt;
  day_cnt_t    s5_y0_r, s5_y0_nxt;
  day_cnt_t    s5_y1_r, s5_y1_nxt;
  day_cnt_t    s5_days_r, s5_days_nxt;
  logic [4:0]  s5_h0_r, s5_h0_nxt;
  logic [12:0] s5_ht_r, s5_ht_nxt;
  logic [12:0] s5_hx_r, s5_hx_nxt;
  logic [3:0]  s5_hlo_r, s5_hlo_nxt;
  // stage 6
  day_cnt_t    s6_base;
  logic [12:0] s6_hdiff;
  logic        s6_hge;
  logic [12:0] s6_hrr;
  yidx_t       s6_n_r, s6_n_nxt;
  doy_t        s6_doy_r, s6_doy_nxt;
  logic        s6_leap_r, s6_leap_nxt;
  logic [4:0]  s6_hour_r, s6_hour_nxt;
  logic [11:0] s6_soh_r, s6_soh_nxt;
  // stage 7
  mon_idx_t    s7_mon_r, s7_mon_nxt;
  doy_t        s7_doy_r, s7_doy_nxt;
  logic        s7_leap_r, s7_leap_nxt;
  yidx_t       s7_n_r, s7_n_nxt;
  logic [4:0]  s7_hour_r, s7_hour_nxt;
  logic [9:0]  s7_my_r, s7_my_nxt;
  logic [20:0] s7_mprod_r, s7_mprod_nxt;
  logic [1:0]  s7_slo_r, s7_slo_nxt;
  // output stage
  logic [5:0]        s8_m0;
  logic [9:0]        s8_mdiff;
  logic              s8_mge;
  logic [9:0]        s8_mrr;
  doy_t              s8_dom;
  logic [YearW-1:0]  o_year_r, o_year_nxt;
  logic [MonthW-1:0] o_month_r, o_month_nxt;
  logic [DayW-1:0]   o_day_r, o_day_nxt;
  logic [HourW-1:0]  o_hour_r, o_hour_nxt;
  logic [MinW-1:0]   o_minute_r, o_minute_nxt;
  logic [SecW-1:0]   o_second_r, o_second_nxt;

  assign pipe_en     = !vld_r[7] || out_ch.ready;
  assign in_ch.ready = pipe_en;
  assign vld_nxt     = {vld_r[6:0], in_ch.valid};

  // stage 1: split off the low seven bits, reciprocal product for /675
  always_comb begin
    s1_x_nxt    = in_ch.unix_seconds[31:7];
    s1_lo_nxt   = in_ch.unix_seconds[6:0];
    s1_prod_nxt = 51'(s1_x_nxt) * 51'(DayRecip);
  end

  // stage 2: day estimate and its back product
  always_comb begin
    s2_q0_nxt = s1_prod_r[50:35];
    s2_t_nxt  = 26'(s2_q0_nxt) * 26'(DayDivLo);
    s2_x_nxt  = s1_x_r;
    s2_lo_nxt = s1_lo_r;
  end

  // stage 3: correct day count, seconds of day
  always_comb begin
    s3_diff     = s2_x_r - 25'(s2_t_r);
    s3_ge       = s3_diff >= 25'(DayDivLo);
    s3_rr       = s3_ge ? (s3_diff - 25'(DayDivLo)) : s3_diff;
    s3_days_nxt = s2_q0_r + 16'(s3_ge);
    s3_sod_nxt  = {s3_rr[9:0], s2_lo_r};
  end

  // stage 4: year and hour reciprocal products
  always_comb begin
    s4_yprod_nxt = 32'(s3_days_r) * 32'(YearRecip);
    s4_days_nxt  = s3_days_r;
    s4_hprod_nxt = 22'(s3_sod_r[16:4]) * 22'(HourRecip);
    s4_sod_nxt   = s3_sod_r;
  end

  // stage 5: year starts around the estimate, hour back product
  always_comb begin
    s5_e_nxt    = s4_yprod_r[31:24];
    s5_ym1_nxt  = year_start(s5_e_nxt - 8'd1);
    s5_y0_nxt   = year_start(s5_e_nxt);
    s5_y1_nxt   = year_start(s5_e_nxt + 8'd1);
    s5_days_nxt = s4_days_r;
    s5_h0_nxt   = s4_hprod_r[20:16];
    s5_ht_nxt   = 13'(s5_h0_nxt) * 13'(HourDivLo);
    s5_hx_nxt   = s4_sod_r[16:4];
    s5_hlo_nxt  = s4_sod_r[3:0];
  end

  // stage 6: pick the year, day of year, correct hour
  always_comb begin
    if (s5_days_r < s5_y0_r) begin
      s6_n_nxt = s5_e_r - 8'd1;
      s6_base  = s5_ym1_r;
    end else if (s5_days_r >= s5_y1_r) begin
      s6_n_nxt = s5_e_r + 8'd1;
      s6_base  = s5_y1_r;
    end else begin
      s6_n_nxt = s5_e_r;
      s6_base  = s5_y0_r;
    end
    s6_doy_nxt  = 9'(s5_days_r - s6_base);
    s6_leap_nxt = is_leap(s6_n_nxt);
    s6_hdiff    = s5_hx_r - s5_ht_r;
    s6_hge      = s6_hdiff >= 13'(HourDivLo);
    s6_hrr      = s6_hge ? (s6_hdiff - 13'(HourDivLo)) : s6_hdiff;
    s6_hour_nxt = s5_h0_r + 5'(s6_hge);
    s6_soh_nxt  = {s6_hrr[7:0], s5_hlo_r};
  end

  // stage 7: month by parallel compare, minute reciprocal product
  always_comb begin
    s7_mon_nxt = '0;
    for (int i = 0; i < NumMonths - 1; i++) begin
      if (s6_doy_r >= month_end(4'(i), s6_leap_r)) begin
        s7_mon_nxt = s7_mon_nxt + 4'd1;
      end
    end
    s7_doy_nxt   = s6_doy_r;
    s7_leap_nxt  = s6_leap_r;
    s7_n_nxt     = s6_n_r;
    s7_hour_nxt  = s6_hour_r;
    s7_my_nxt    = s6_soh_r[11:2];
    s7_mprod_nxt = 21'(s7_my_nxt) * 21'(MinRecip);
    s7_slo_nxt   = s6_soh_r[1:0];
  end

  // output stage: correct the minute, assemble the date and time of day
  always_comb begin
    s8_m0        = s7_mprod_r[19:14];
    s8_mdiff     = s7_my_r - 10'(s8_m0) * 10'(MinDivLo);
    s8_mge       = s8_mdiff >= 10'(MinDivLo);
    s8_mrr       = s8_mge ? (s8_mdiff - 10'(MinDivLo)) : s8_mdiff;
    s8_dom       = s7_doy_r - month_start(s7_mon_r, s7_leap_r) + 9'd1;
    o_year_nxt   = EpochYear + 12'(s7_n_r);
    o_month_nxt  = s7_mon_r + 4'd1;
    o_day_nxt    = s8_dom[4:0];
    o_hour_nxt   = s7_hour_r;
    o_minute_nxt = s8_m0 + 6'(s8_mge);
    o_second_nxt = {s8_mrr[3:0], s7_slo_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (pipe_en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_x_r      <= s1_x_nxt;
      s1_lo_r     <= s1_lo_nxt;
      s1_prod_r   <= s1_prod_nxt;
      s2_q0_r     <= s2_q0_nxt;
      s2_t_r      <= s2_t_nxt;
      s2_x_r      <= s2_x_nxt;
      s2_lo_r     <= s2_lo_nxt;
      s3_days_r   <= s3_days_nxt;
      s3_sod_r    <= s3_sod_nxt;
      s4_yprod_r  <= s4_yprod_nxt;
      s4_days_r   <= s4_days_nxt;
      s4_hprod_r  <= s4_hprod_nxt;
      s4_sod_r    <= s4_sod_nxt;
      s5_e_r      <= s5_e_nxt;
      s5_ym1_r    <= s5_ym1_nxt;
      s5_y0_r     <= s5_y0_nxt;
      s5_y1_r     <= s5_y1_nxt;
      s5_days_r   <= s5_days_nxt;
      s5_h0_r     <= s5_h0_nxt;
      s5_ht_r     <= s5_ht_nxt;
      s5_hx_r     <= s5_hx_nxt;
      s5_hlo_r    <= s5_hlo_nxt;
      s6_n_r      <= s6_n_nxt;
      s6_doy_r    <= s6_doy_nxt;
      s6_leap_r   <= s6_leap_nxt;
      s6_hour_r   <= s6_hour_nxt;
      s6_soh_r    <= s6_soh_nxt;
      s7_mon_r    <= s7_mon_nxt;
      s7_doy_r    <= s7_doy_nxt;
      s7_leap_r   <= s7_leap_nxt;
      s7_n_r      <= s7_n_nxt;
      s7_hour_r   <= s7_hour_nxt;
      s7_my_r     <= s7_my_nxt;
      s7_mprod_r  <= s7_mprod_nxt;
      s7_slo_r    <= s7_slo_nxt;
      o_year_r    <= o_year_nxt;
      o_month_r   <= o_month_nxt;
      o_day_r     <= o_day_nxt;
      o_hour_r    <= o_hour_nxt;
      o_minute_r  <= o_minute_nxt;
      o_second_r  <= o_second_nxt;
    end
  end

  assign out_ch.valid  = vld_r[7];
  assign out_ch.year   = o_year_r;
  assign out_ch.month  = o_month_r;
  assign out_ch.day    = o_day_r;
  assign out_ch.hour   = o_hour_r;
  assign out_ch.minute = o_minute_r;
  assign out_ch.second = o_second_r;

`ifndef SYNTHESIS
  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.month >= 4'd1 && out_ch.month <= 4'd12 &&
                      out_ch.day >= 5'd1 && out_ch.year >= EpochYear))
    else $error("calendar date out of range");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.hour < 5'd24 && out_ch.minute < 6'd60 &&
                      out_ch.second < 6'd60))
    else $error("time of day out of range");

  a_year_pick: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[4] |-> ((s5_e_r == '0 || s5_days_r >= s5_ym1_r) &&
                  s5_days_r < year_start(s5_e_r + 8'd2)))
    else $error("year estimate off by more than one");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!pipe_en && vld_r[5]) |=> ($stable(s6_doy_r) && $stable(s6_n_r) && vld_r[5]))
    else $error("pipeline stage changed while stalled");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (pipe_en && vld_r[6]) |=> vld_r[7])
    else $error("item lost between last stages");
`endif

endmodule
